@@ rtl/fstp_pkg.sv @@
// Shared types, constants and saturating helpers for the fair-share task picker.
`default_nettype none

package fstp_pkg;

  // Field widths
  localparam int RUN_W    = 8;
  localparam int CFG_W    = 5;
  localparam int TASK_W   = 4;
  localparam int GRANT_W  = 12;
  localparam int CREDIT_W = 24;
  localparam int TOTAL_W  = 48;

  // Largest grant that is reported and booked
  localparam logic [GRANT_W-1:0] GRANT_CAP = {GRANT_W{1'b1}};

  typedef logic signed [CREDIT_W-1:0] credit_t;
  typedef logic [TOTAL_W-1:0]         total_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch the run time, compute the grant, rewind the address
    logic scan_rd;  // read one credit for the max search
    logic upd_rd;   // read one credit for the update pass
    logic cum_rd;   // read the chosen task's total
    logic finish;   // book the total and present the result word
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic addr_last;  // address sits on the last active entry
  } sts_t;

  // Add a run time to a credit, clamping to the signed range
  function automatic credit_t sat_add(credit_t c, logic [RUN_W-1:0] r);
    logic signed [CREDIT_W:0] s;
    s = $signed({c[CREDIT_W-1], c}) + $signed({{(CREDIT_W+1-RUN_W){1'b0}}, r});
    if (s[CREDIT_W] != s[CREDIT_W-1]) begin
      return s[CREDIT_W] ? {1'b1, {(CREDIT_W-1){1'b0}}} : {1'b0, {(CREDIT_W-1){1'b1}}};
    end
    return s[CREDIT_W-1:0];
  endfunction

  // Subtract a grant from a credit, clamping to the signed range
  function automatic credit_t sat_sub(credit_t c, logic [GRANT_W-1:0] g);
    logic signed [CREDIT_W:0] s;
    s = $signed({c[CREDIT_W-1], c}) - $signed({{(CREDIT_W+1-GRANT_W){1'b0}}, g});
    if (s[CREDIT_W] != s[CREDIT_W-1]) begin
      return s[CREDIT_W] ? {1'b1, {(CREDIT_W-1){1'b0}}} : {1'b0, {(CREDIT_W-1){1'b1}}};
    end
    return s[CREDIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/fstp_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module fstp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/fstp_ctrl.sv @@
// Sequencer for the scan, update and booking passes of the task picker.
`default_nettype none

module fstp_ctrl
  import fstp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o,
  output logic      busy_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl_o.scan_rd = 1'b1;
        if (sts_i.addr_last) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        ctl_o.upd_rd = 1'b1;
        if (sts_i.addr_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        ctl_o.cum_rd = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        ctl_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/fstp_dpath.sv @@
// Datapath: task count register, credit and total stores, max search and updates.
`default_nettype none

module fstp_dpath
  import fstp_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctl_t                ctl_i,
  output sts_t                     sts_o,
  input  wire logic [RUN_W-1:0]    run_time_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  output logic                     done_o,
  output logic [TASK_W-1:0]        chosen_task_o,
  output logic [GRANT_W-1:0]       granted_time_o,
  output logic [TOTAL_W-1:0]       chosen_total_o
);

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int PROD_W = (RUN_W + CNT_W > GRANT_W) ? (RUN_W + CNT_W) : GRANT_W;
  localparam logic [CNT_W-1:0] CNT_RST = CNT_W'((MAX_TASKS < 10) ? MAX_TASKS : 10);

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     addr_q, addr_d;
  logic [IDX_W-1:0]     last_idx;
  logic [RUN_W-1:0]     run_q;
  logic [GRANT_W-1:0]   grant_q, grant_d;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 cmp_pend_q;
  logic                 wr_pend_q;
  credit_t              best_q;
  logic [IDX_W-1:0]     pick_q;
  logic [MAX_TASKS-1:0] crd_vld_q;
  logic [MAX_TASKS-1:0] cum_vld_q;
  logic                 done_q;
  logic [TASK_W-1:0]    task_q;
  logic [GRANT_W-1:0]   gtime_q;
  total_t               total_q;

  logic [CREDIT_W-1:0]  crd_rdata;
  logic [TOTAL_W-1:0]   cum_rdata;
  credit_t              crd_cur;
  credit_t              crd_add;
  credit_t              crd_new;
  total_t               cum_cur;
  total_t               cum_new;

  // Clamp a written task count to one .. MAX_TASKS
  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cnt_d = CNT_W'(1);
      end else if (32'(cfg_wdata_i) > 32'(MAX_TASKS)) begin
        cnt_d = CNT_W'(MAX_TASKS);
      end else begin
        cnt_d = CNT_W'(cfg_wdata_i);
      end
    end
  end

  // Grant: run time times task count, capped
  assign prod = PROD_W'(run_time_i) * PROD_W'(cnt_q);
  assign grant_d = (prod > PROD_W'(GRANT_CAP)) ? GRANT_CAP : GRANT_W'(prod);

  // Walk the active entries, wrapping to zero after the last one
  assign last_idx        = IDX_W'(cnt_q - CNT_W'(1));
  assign sts_o.addr_last = (addr_q == last_idx);

  always_comb begin
    addr_d = addr_q;
    if (ctl_i.load) begin
      addr_d = '0;
    end else if (ctl_i.scan_rd || ctl_i.upd_rd) begin
      addr_d = sts_o.addr_last ? '0 : addr_q + IDX_W'(1);
    end
  end

  // Never-written entries read as zero
  assign crd_cur = crd_vld_q[rd_idx_q] ? $signed(crd_rdata) : '0;
  assign crd_add = sat_add(crd_cur, run_q);
  assign crd_new = (rd_idx_q == pick_q) ? sat_sub(crd_add, grant_q) : crd_add;

  assign cum_cur = cum_vld_q[pick_q] ? cum_rdata : '0;
  assign cum_new = cum_cur + TOTAL_W'(grant_q);

  fstp_ram #(
    .WIDTH (CREDIT_W),
    .DEPTH (MAX_TASKS)
  ) u_credit_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (rd_idx_q),
    .wdata_i (crd_new),
    .re_i    (ctl_i.scan_rd || ctl_i.upd_rd),
    .raddr_i (addr_q),
    .rdata_o (crd_rdata)
  );

  fstp_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (MAX_TASKS)
  ) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.finish),
    .waddr_i (pick_q),
    .wdata_i (cum_new),
    .re_i    (ctl_i.cum_rd),
    .raddr_i (pick_q),
    .rdata_o (cum_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= CNT_RST;
      addr_q     <= '0;
      cmp_pend_q <= 1'b0;
      wr_pend_q  <= 1'b0;
      crd_vld_q  <= '0;
      cum_vld_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      addr_q     <= addr_d;
      cmp_pend_q <= ctl_i.scan_rd;
      wr_pend_q  <= ctl_i.upd_rd;
      done_q     <= ctl_i.finish;
      if (wr_pend_q) begin
        crd_vld_q[rd_idx_q] <= 1'b1;
      end
      if (ctl_i.finish) begin
        cum_vld_q[pick_q] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      run_q   <= run_time_i;
      grant_q <= grant_d;
    end
    if (ctl_i.scan_rd || ctl_i.upd_rd) begin
      rd_idx_q <= addr_q;
    end
    // Keep the largest credit; a tie keeps the lower index
    if (cmp_pend_q) begin
      if (rd_idx_q == '0 || crd_cur > best_q) begin
        best_q <= crd_cur;
        pick_q <= rd_idx_q;
      end
    end
    if (ctl_i.finish) begin
      task_q  <= TASK_W'(pick_q);
      gtime_q <= grant_q;
      total_q <= cum_new;
    end
  end

  assign done_o         = done_q;
  assign chosen_task_o  = task_q;
  assign granted_time_o = gtime_q;
  assign chosen_total_o = total_q;

endmodule

`default_nettype wire

@@ rtl/fair_share_task_picker_unit.sv @@
// Top level of the fair-share task picker: controller, datapath and checks.
`default_nettype none

// Each word on start_i/run_time_i asks for one scheduling decision. The unit
// picks the active task with the largest signed credit (lowest index on a
// tie), grants it run_time * active_tasks (capped at 4095), raises every
// active credit by run_time with saturation, charges the grant to the chosen
// task and adds it to that task's 48-bit wrapping total. The result word is
// shown for exactly one cycle with done_o high and cannot be held off. A
// new word is not taken until the decision before it is done: the single
// read port of the credit memory is walked once to find the maximum and
// once more to write back the updated credits, then the chosen total is
// read and booked. busy_o is high while a decision is in flight; the
// result strobe lands in the first cycle that busy_o is low again, so a
// new start can be taken in that same cycle. Credits and totals read as zero
// after reset with no clearing pass. Write cfg_we_i/cfg_wdata_i only while
// busy_o is low; the task count is stored clamped to one .. MAX_TASKS.
module fair_share_task_picker_unit
  import fstp_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [RUN_W-1:0]   run_time_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  output logic                    done_o,
  output logic [TASK_W-1:0]       chosen_task_o,
  output logic [GRANT_W-1:0]      granted_time_o,
  output logic [TOTAL_W-1:0]      chosen_total_o
);

  ctl_t ctl;
  sts_t sts;
  logic u_dpath_run_zero;
  logic run_zero_q;

  fstp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy_o)
  );

  fstp_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .run_time_i     (run_time_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .chosen_task_o  (chosen_task_o),
    .granted_time_o (granted_time_o),
    .chosen_total_o (chosen_total_o)
  );

  // Track whether the word in flight carried a zero run time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_zero_q <= 1'b0;
    end else if (start_i && !busy_o) begin
      run_zero_q <= (run_time_i == '0);
    end
  end

  assign u_dpath_run_zero = run_zero_q;

  // An accepted word makes the unit busy on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  // The result strobe comes only as the unit turns idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && $past(busy_o)))
    else $error("result strobe outside the end of a decision");

  // A grant of zero only follows a zero run time
  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (granted_time_o == '0)) |-> (u_dpath_run_zero))
    else $error("zero grant from a nonzero run time");

endmodule

`default_nettype wire
